>>> rtl/bvsoc_pkg.sv
// ----------------------------------------------------------------------------
// bvsoc_pkg: shared types and constants
// Field widths, item classification and register indexes for the battery
// voltage averager with state-of-charge lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package bvsoc_pkg;

  localparam int unsigned SampleW  = 23;
  localparam int unsigned IdxW     = 7;
  localparam int unsigned MvW      = 16;
  localparam int unsigned SocW     = 11;
  localparam int unsigned ShiftW   = 4;
  localparam int unsigned LeftW    = 9;
  localparam int unsigned SumW     = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  localparam logic [ShiftW-1:0] MaxShift        = 4'd8;
  localparam logic [ShiftW-1:0] LongShiftReset  = 4'd8;
  localparam logic [ShiftW-1:0] ShortShiftReset = 4'd4;

  // Divide by 1000 as a multiply by ceil(2^33 / 1000); exact for inputs below 2^24.
  localparam int unsigned  UvPerMv    = 1000;
  localparam int unsigned  RecipShift = 33;
  localparam int unsigned  RecipW     = 24;
  localparam logic [RecipW-1:0] RecipMult =
    RecipW'((64'd1 << RecipShift) / UvPerMv + 64'd1);
  localparam int unsigned  ProdW      = SampleW + RecipW;

  localparam int unsigned SocScaleLog = 4;
  localparam int unsigned FullPercent = 100;
  localparam logic [SocW-1:0] FullSoc = SocW'(FullPercent << SocScaleLog);

  localparam logic CMD_SAMPLE      = 1'b0;
  localparam logic CMD_TABLE_WRITE = 1'b1;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_WRITE  = 2'd1,
    OP_SKIP   = 2'd2
  } op_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LONG_SHIFT  = 2'd0,
    REG_SHORT_SHIFT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    op_kind_e           kind;
    logic [SampleW-1:0] sample_uv;
    logic [IdxW-1:0]    entry_index;
    logic [MvW-1:0]     entry_mv;
  } op_t;

  typedef struct packed {
    logic [MvW-1:0]  long_avg_mv;
    logic            long_done;
    logic [MvW-1:0]  short_avg_mv;
    logic            short_done;
    logic [SocW-1:0] soc_x16;
    logic            init_seen;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/battery_voltage_average_soc_lookup.sv
// ----------------------------------------------------------------------------
// battery_voltage_average_soc_lookup: voltage averager with SOC lookup
// Long and short block averages of microvolt samples, with state of charge
// looked up from a software-written open-circuit voltage table.
// ----------------------------------------------------------------------------
// Each input word is either a voltage sample or a write of one table entry,
// and each one returns exactly one result word. A sample that completes no
// window goes from the queue head to the output register; one that
// completes a window first passes the shared divide-by-1000 multiplier, and
// a completed short window adds the table end checks and a binary search on
// the table RAM read port, one probe at a time, up to
// ceil(log2(TABLE_ENTRIES - 1)) probes (7 for 100 entries). A two-word queue
// takes new words while the back end works, and the output register holds a
// finished result while the next word is worked on. The table has no reset:
// fill every entry before the first short window completes. Register writes
// take effect at once, restart their window, and must only be issued while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_voltage_average_soc_lookup import bvsoc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 100
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input channel
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic                cmd_i,
  input  wire logic [SampleW-1:0]  sample_uv_i,
  input  wire logic [IdxW-1:0]     entry_index_i,
  input  wire logic [MvW-1:0]      entry_mv_i,
  // Result channel
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [MvW-1:0]      long_avg_mv_o,
  output      logic                long_done_o,
  output      logic [MvW-1:0]      short_avg_mv_o,
  output      logic                short_done_o,
  output      logic [SocW-1:0]     soc_x16_o,
  output      logic                init_seen_o,
  // Register write channel
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  op_t     push_op, head_op;
  logic    push, pop;
  logic    q_full, q_empty;
  result_t res;

  // Classify words and push them into the queue.
  bvsoc_front #(
    .TableEntries (TABLE_ENTRIES)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .sample_uv_i   (sample_uv_i),
    .entry_index_i (entry_index_i),
    .entry_mv_i    (entry_mv_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .op_o          (push_op)
  );

  bvsoc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (pop),
    .op_o    (head_op)
  );

  // Execute one word at a time and hold its result until taken.
  bvsoc_back #(
    .TableEntries (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (~q_empty),
    .op_i        (head_op),
    .op_pop_o    (pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // Registers are always writable.
  assign cfg_ready_o = 1'b1;

  assign long_avg_mv_o  = res.long_avg_mv;
  assign long_done_o    = res.long_done;
  assign short_avg_mv_o = res.short_avg_mv;
  assign short_done_o   = res.short_done;
  assign soc_x16_o      = res.soc_x16;
  assign init_seen_o    = res.init_seen;

  // A stalled input means the queue holds work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !q_empty)
    else $error("input stalled while work queue is empty");

  // A completed long window has always set the init flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && long_done_o) |-> init_seen_o)
    else $error("long window done without init flag");

  // The init flag never clears once set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_seen_o |=> init_seen_o)
    else $error("init flag dropped");

endmodule

`default_nettype wire

>>> rtl/bvsoc_ram.sv
// ----------------------------------------------------------------------------
// bvsoc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bvsoc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 100
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/bvsoc_front.sv
// ----------------------------------------------------------------------------
// bvsoc_front: input acceptance and classification
// Takes words from the input channel, sorts them into sample, table write
// or ignored write, and pushes them into the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bvsoc_front import bvsoc_pkg::*; #(
  parameter int unsigned TableEntries = 100
) (
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic               cmd_i,
  input  wire logic [SampleW-1:0] sample_uv_i,
  input  wire logic [IdxW-1:0]    entry_index_i,
  input  wire logic [MvW-1:0]     entry_mv_i,
  input  wire logic               q_full_i,
  output      logic               push_o,
  output      op_t                op_o
);

  logic in_range;

  // Widen by one bit so a 128-entry table compares correctly.
  assign in_range = {1'b0, entry_index_i} < (IdxW + 1)'(TableEntries);

  always_comb begin
    op_o.sample_uv   = sample_uv_i;
    op_o.entry_index = entry_index_i;
    op_o.entry_mv    = entry_mv_i;
    if (cmd_i == CMD_TABLE_WRITE) begin
      op_o.kind = in_range ? OP_WRITE : OP_SKIP;
    end else begin
      op_o.kind = OP_SAMPLE;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

endmodule

`default_nettype wire

>>> rtl/bvsoc_queue.sv
// ----------------------------------------------------------------------------
// bvsoc_queue: short work queue
// Small FIFO between the front and the back so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module bvsoc_queue import bvsoc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  output      logic full_o,
  output      logic empty_o,
  input  wire logic pop_i,
  output      op_t  op_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  op_t               slot_q [QueueDepth];
  logic [PtrW-1:0]   wptr_q, wptr_d;
  logic [PtrW-1:0]   rptr_q, rptr_d;
  logic [PtrW:0]     count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = count_q == (PtrW + 1)'(QueueDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign op_o    = slot_q[rptr_q];

  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bvsoc_back.sv
// ----------------------------------------------------------------------------
// bvsoc_back: averaging, division and table search
// Executes queued work: table writes, window accumulation, divide by 1000
// through a shared reciprocal multiplier, binary search of the voltage
// table, and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bvsoc_back import bvsoc_pkg::*; #(
  parameter int unsigned TableEntries = 100
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                op_valid_i,
  input  wire op_t                 op_i,
  output      logic                op_pop_o,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      result_t             res_o
);

  localparam int unsigned TIdxW = $clog2(TableEntries);
  localparam logic [TIdxW-1:0] LastIdx  = TIdxW'(TableEntries - 1);
  localparam logic [TIdxW-1:0] FirstMid = TIdxW'((TableEntries - 1) / 2);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIVL   = 8'b0000_0010,
    S_DIVS   = 8'b0000_0100,
    S_DIVE   = 8'b0000_1000,
    S_PFIRST = 8'b0001_0000,
    S_PLAST  = 8'b0010_0000,
    S_SRCH   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } back_state_e;

  function automatic logic [ShiftW-1:0] eff_shift(logic [ShiftW-1:0] s);
    return (s > MaxShift) ? MaxShift : s;
  endfunction

  function automatic logic [LeftW-1:0] win_len(logic [ShiftW-1:0] s);
    return LeftW'(1) << s;
  endfunction

  back_state_e        state_q, state_d;
  logic [ShiftW-1:0]  long_shift_q, short_shift_q;
  logic [SumW-1:0]    long_sum_q, short_sum_q;
  logic [LeftW-1:0]   long_left_q, short_left_q;
  logic [MvW-1:0]     long_avg_q, short_avg_q;
  logic               long_done_q, short_done_q;
  logic [SocW-1:0]    soc_q;
  logic               init_q;
  logic               out_valid_q;
  result_t            res_q;
  logic [SampleW-1:0] long_x_q, short_x_q;
  logic [ProdW-1:0]   prod_q;
  logic [TIdxW-1:0]   lo_q, hi_q;

  logic [SumW-1:0]    long_sum_n, short_sum_n;
  logic [LeftW-1:0]   long_left_n, short_left_n;
  logic               long_wrap, short_wrap;
  logic [SampleW-1:0] mul_a;
  logic [MvW-1:0]     quot;
  logic [TIdxW:0]     sum_cur, sum_n;
  logic [TIdxW-1:0]   mid_cur, lo_n, hi_n, mid_n;
  logic               more;
  logic               avg_gt, avg_lt;
  logic               out_free;
  logic               ram_we;
  logic [TIdxW-1:0]   ram_raddr;
  logic [MvW-1:0]     ram_rdata;

  bvsoc_ram #(
    .Width (MvW),
    .Depth (TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (op_i.entry_index[TIdxW-1:0]),
    .wdata_i (op_i.entry_mv),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Window accumulation for the item at the queue head.
  assign long_sum_n   = long_sum_q + SumW'(op_i.sample_uv);
  assign short_sum_n  = short_sum_q + SumW'(op_i.sample_uv);
  assign long_left_n  = long_left_q - 1'b1;
  assign short_left_n = short_left_q - 1'b1;
  assign long_wrap    = long_left_n == '0;
  assign short_wrap   = short_left_n == '0;

  assign mul_a = (state_q == S_DIVL) ? long_x_q : short_x_q;
  assign quot  = MvW'(prod_q >> RecipShift);

  // Search step: rdata holds the entry at the current midpoint.
  assign avg_gt  = short_avg_q > ram_rdata;
  assign avg_lt  = short_avg_q < ram_rdata;
  assign sum_cur = (TIdxW + 1)'(lo_q) + (TIdxW + 1)'(hi_q);
  assign mid_cur = sum_cur[TIdxW:1];
  assign lo_n    = avg_gt ? mid_cur : lo_q;
  assign hi_n    = avg_gt ? hi_q : mid_cur;
  assign sum_n   = (TIdxW + 1)'(lo_n) + (TIdxW + 1)'(hi_n);
  assign mid_n   = sum_n[TIdxW:1];
  assign more    = ((TIdxW + 1)'(lo_n) + 1'b1) < (TIdxW + 1)'(hi_n);

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign op_pop_o = (state_q == S_IDLE) & op_valid_i;
  assign ram_we   = op_pop_o & (op_i.kind == OP_WRITE);

  always_comb begin
    case (state_q)
      S_DIVE:   ram_raddr = '0;
      S_PFIRST: ram_raddr = LastIdx;
      S_PLAST:  ram_raddr = FirstMid;
      S_SRCH:   ram_raddr = mid_n;
      default:  ram_raddr = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          if (op_i.kind == OP_SAMPLE && (long_wrap || short_wrap)) begin
            state_d = S_DIVL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DIVL:   state_d = S_DIVS;
      S_DIVS:   state_d = S_DIVE;
      S_DIVE:   state_d = short_done_q ? S_PFIRST : S_DONE;
      S_PFIRST: state_d = avg_lt ? S_DONE : S_PLAST;
      S_PLAST:  state_d = avg_gt ? S_DONE : S_SRCH;
      S_SRCH:   state_d = more ? S_SRCH : S_DONE;
      S_DONE:   state_d = out_free ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      long_shift_q  <= LongShiftReset;
      short_shift_q <= ShortShiftReset;
      long_sum_q    <= '0;
      short_sum_q   <= '0;
      long_left_q   <= win_len(LongShiftReset);
      short_left_q  <= win_len(ShortShiftReset);
      long_avg_q    <= '0;
      short_avg_q   <= '0;
      long_done_q   <= 1'b0;
      short_done_q  <= 1'b0;
      soc_q         <= '0;
      init_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      res_q         <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (op_valid_i) begin
            long_done_q  <= 1'b0;
            short_done_q <= 1'b0;
            if (op_i.kind == OP_SAMPLE) begin
              // Advance both windows; restart any that completes.
              if (long_wrap) begin
                long_sum_q  <= '0;
                long_left_q <= win_len(long_shift_q);
                long_done_q <= 1'b1;
                init_q      <= 1'b1;
              end else begin
                long_sum_q  <= long_sum_n;
                long_left_q <= long_left_n;
              end
              if (short_wrap) begin
                short_sum_q  <= '0;
                short_left_q <= win_len(short_shift_q);
                short_done_q <= 1'b1;
              end else begin
                short_sum_q  <= short_sum_n;
                short_left_q <= short_left_n;
              end
            end
          end
        end
        S_DIVS: begin
          if (long_done_q) begin
            long_avg_q <= quot;
          end
        end
        S_DIVE: begin
          if (short_done_q) begin
            short_avg_q <= quot;
          end
        end
        S_PFIRST: begin
          if (avg_lt) begin
            soc_q <= '0;
          end
        end
        S_PLAST: begin
          if (avg_gt) begin
            soc_q <= FullSoc;
          end
        end
        S_SRCH: begin
          if (!more) begin
            soc_q <= SocW'(hi_n) << SocScaleLog;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            res_q.long_avg_mv  <= long_avg_q;
            res_q.long_done    <= long_done_q;
            res_q.short_avg_mv <= short_avg_q;
            res_q.short_done   <= short_done_q;
            res_q.soc_x16      <= soc_q;
            res_q.init_seen    <= init_q;
          end
        end
        default: begin
        end
      endcase
      // Register writes must arrive only while idle; this block does not enforce it. A write restarts its window.
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_LONG_SHIFT: begin
            long_shift_q <= eff_shift(cfg_data_i);
            long_sum_q   <= '0;
            long_left_q  <= win_len(eff_shift(cfg_data_i));
          end
          REG_SHORT_SHIFT: begin
            short_shift_q <= eff_shift(cfg_data_i);
            short_sum_q   <= '0;
            short_left_q  <= win_len(eff_shift(cfg_data_i));
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && op_valid_i) begin
      long_x_q  <= SampleW'(long_sum_n >> long_shift_q);
      short_x_q <= SampleW'(short_sum_n >> short_shift_q);
    end
    if (state_q == S_DIVL || state_q == S_DIVS) begin
      prod_q <= ProdW'(mul_a) * ProdW'(RecipMult);
    end
    if (state_q == S_PLAST) begin
      lo_q <= '0;
      hi_q <= LastIdx;
    end else if (state_q == S_SRCH) begin
      lo_q <= lo_n;
      hi_q <= hi_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> bench/bvsoc_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bvsoc_tb_pkg: result predictor for the voltage averager bench
// Keeps its own copy of both window averagers, the voltage table and the
// state of charge, and holds the result words still due from the block.
// ----------------------------------------------------------------------------
package bvsoc_tb_pkg;
  import bvsoc_pkg::*;

  localparam int unsigned TableN   = 100;
  localparam int unsigned PrintCap = 120;

  class voltage_soc_shadow;
    logic [ShiftW-1:0] long_shift, short_shift;
    logic [SumW-1:0]   long_acc, short_acc;
    logic [LeftW-1:0]  long_cnt, short_cnt;
    logic [MvW-1:0]    long_mv, short_mv;
    logic [SocW-1:0]   soc_q;
    logic              init_q;
    logic [MvW-1:0]    curve [TableN];
    result_t           due_q [$];
    int unsigned       bad_fields;

    function new();
      long_shift  = LongShiftReset;
      short_shift = ShortShiftReset;
      long_acc    = '0;
      short_acc   = '0;
      long_cnt    = win_len(long_shift);
      short_cnt   = win_len(short_shift);
      long_mv     = '0;
      short_mv    = '0;
      soc_q       = '0;
      init_q      = 1'b0;
      bad_fields  = 0;
      foreach (curve[i]) curve[i] = '0;
    endfunction

    // Values above the largest window act as the largest window.
    function int unsigned eff_shift(logic [ShiftW-1:0] s);
      return (s > MaxShift) ? MaxShift : s;
    endfunction

    function logic [LeftW-1:0] win_len(logic [ShiftW-1:0] s);
      return LeftW'(1 << eff_shift(s));
    endfunction

    // A shift write restarts only its own window.
    function void set_reg(cfg_reg_e r, logic [ShiftW-1:0] v);
      if (r == REG_LONG_SHIFT) begin
        long_shift = v;
        long_acc   = '0;
        long_cnt   = win_len(v);
      end else if (r == REG_SHORT_SHIFT) begin
        short_shift = v;
        short_acc   = '0;
        short_cnt   = win_len(v);
      end
    endfunction

    function int unsigned lookup_percent(logic [MvW-1:0] mv);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = TableN - 1;
      if (mv < curve[0]) return 0;
      if (mv > curve[TableN-1]) return FullPercent;
      while (lo + 1 < hi) begin
        mid = (lo + hi) >> 1;
        if (mv > curve[mid]) lo = mid;
        else hi = mid;
      end
      return hi;
    endfunction

    // Note one accepted input word and queue the result word it causes.
    function void take_word(logic cmd, logic [SampleW-1:0] s, logic [IdxW-1:0] idx,
                            logic [MvW-1:0] emv);
      result_t         r;
      logic [SumW-1:0] scaled;
      r.long_done  = 1'b0;
      r.short_done = 1'b0;
      if (cmd == CMD_TABLE_WRITE) begin
        if (idx < TableN) curve[idx] = emv;
      end else begin
        long_acc = long_acc + SumW'(s);
        long_cnt = long_cnt - 1'b1;
        if (long_cnt == '0) begin
          scaled      = long_acc >> eff_shift(long_shift);
          long_mv     = MvW'(scaled / UvPerMv);
          long_acc    = '0;
          long_cnt    = win_len(long_shift);
          init_q      = 1'b1;
          r.long_done = 1'b1;
        end
        short_acc = short_acc + SumW'(s);
        short_cnt = short_cnt - 1'b1;
        if (short_cnt == '0) begin
          scaled       = short_acc >> eff_shift(short_shift);
          short_mv     = MvW'(scaled / UvPerMv);
          short_acc    = '0;
          short_cnt    = win_len(short_shift);
          soc_q        = SocW'(lookup_percent(short_mv) << SocScaleLog);
          r.short_done = 1'b1;
        end
      end
      r.long_avg_mv  = long_mv;
      r.short_avg_mv = short_mv;
      r.soc_x16      = soc_q;
      r.init_seen    = init_q;
      due_q.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        bad_fields++;
        if (bad_fields <= PrintCap)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare one result word with the oldest one due.
    function void match_result(result_t got);
      result_t want;
      if (due_q.size() == 0) begin
        bad_fields++;
        if (bad_fields <= PrintCap)
          $display("%0t: result word with nothing due, actual %h", $time, got);
        return;
      end
      want = due_q.pop_front();
      check_field("long_avg_mv", want.long_avg_mv, got.long_avg_mv);
      check_field("long_done", want.long_done, got.long_done);
      check_field("short_avg_mv", want.short_avg_mv, got.short_avg_mv);
      check_field("short_done", want.short_done, got.short_done);
      check_field("soc_x16", want.soc_x16, got.soc_x16);
      check_field("init_seen", want.init_seen, got.init_seen);
    endfunction

    function int unsigned due_count();
      return due_q.size();
    endfunction
  endclass

endpackage

>>> bench/tb_battery_voltage_average_soc_lookup.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_battery_voltage_average_soc_lookup: bench for the voltage averager
// Fills the voltage table, runs directed corner words, then random phases
// under several window settings with bursty input and a stalling receiver;
// every result word is checked field by field against a predictor.
// ----------------------------------------------------------------------------
module tb_battery_voltage_average_soc_lookup;
  import bvsoc_pkg::*;
  import bvsoc_tb_pkg::*;

  localparam int unsigned SettleCycles = 20;
  localparam int unsigned MaxUv        = 4300000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                cmd = CMD_SAMPLE;
  logic [SampleW-1:0]  sample_uv = '0;
  logic [IdxW-1:0]     entry_index = '0;
  logic [MvW-1:0]      entry_mv = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [MvW-1:0]      long_avg_mv;
  logic                long_done;
  logic [MvW-1:0]      short_avg_mv;
  logic                short_done;
  logic [SocW-1:0]     soc_x16;
  logic                init_seen;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  voltage_soc_shadow sb;

  // Stimulus side copy of the intended (monotone) table, and entries that
  // noise writes have spoiled and that must be put back at phase end.
  logic [MvW-1:0] curve_mv [TableN];
  int unsigned    dirty_q [$];
  int unsigned    level_uv = 0;
  int             burst_left = 0;

  battery_voltage_average_soc_lookup #(
    .TABLE_ENTRIES(TableN)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .sample_uv_i   (sample_uv),
    .entry_index_i (entry_index),
    .entry_mv_i    (entry_mv),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .long_avg_mv_o (long_avg_mv),
    .long_done_o   (long_done),
    .short_avg_mv_o(short_avg_mv),
    .short_done_o  (short_done),
    .soc_x16_o     (soc_x16),
    .init_seen_o   (init_seen),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: check the word accepted at this edge, then pick the stall
  // for the next cycle. Stall modes change at random so that free-running
  // stretches alternate with light, heavy and long stalls.
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_age = 0;
  int unsigned stall_run = 0;
  logic        stall_hold = 1'b0;

  always @(posedge clk) begin : watch_results
    result_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.long_avg_mv  = long_avg_mv;
      seen.long_done    = long_done;
      seen.short_avg_mv = short_avg_mv;
      seen.short_done   = short_done;
      seen.soc_x16      = soc_x16;
      seen.init_seen    = init_seen;
      sb.match_result(seen);
    end
    if (stall_age == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_age  = $urandom_range(40, 160);
    end else begin
      stall_age--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default: begin
        if (stall_run == 0) begin
          stall_hold = ~stall_hold;
          stall_run  = $urandom_range(1, 20);
        end else begin
          stall_run--;
        end
        out_stall <= stall_hold;
      end
    endcase
  end

  // Drive one input word and hold it until accepted, then note it. Words go
  // out in bursts; between bursts drop valid for a random gap. A zero gap
  // keeps valid high so it is never lowered and raised in one step.
  task automatic send_word(logic c, logic [SampleW-1:0] s, logic [IdxW-1:0] i,
                           logic [MvW-1:0] v);
    int gap;
    in_valid    <= 1'b1;
    cmd         <= c;
    sample_uv   <= s;
    entry_index <= i;
    entry_mv    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_word(c, s, i, v);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(10, 25);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Unused fields carry random junk so the block must ignore them.
  task automatic post_sample(int unsigned s);
    send_word(CMD_SAMPLE, SampleW'(s), IdxW'($urandom), MvW'($urandom));
  endtask

  task automatic post_entry(int unsigned i, int unsigned v);
    send_word(CMD_TABLE_WRITE, SampleW'($urandom), IdxW'(i), MvW'(v));
  endtask

  // Wait until every result word is in, then let the block settle.
  task automatic idle_block();
    in_valid <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write both window shifts back to back with valid held high.
  task automatic set_windows(logic [ShiftW-1:0] lw, logic [ShiftW-1:0] sw);
    idle_block();
    cfg_valid <= 1'b1;
    cfg_index <= REG_LONG_SHIFT;
    cfg_data  <= lw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(REG_LONG_SHIFT, lw);
    cfg_index <= REG_SHORT_SHIFT;
    cfg_data  <= sw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(REG_SHORT_SHIFT, sw);
    cfg_valid <= 1'b0;
  endtask

  // Fill every entry with a non-decreasing curve, repeats allowed, that
  // stays under the largest possible average so both ends are reachable.
  task automatic load_curve();
    int unsigned mv;
    mv = 3000 + $urandom_range(0, 200);
    for (int i = 0; i < TableN; i++) begin
      curve_mv[i] = MvW'(mv);
      post_entry(i, mv);
      mv += $urandom_range(0, 11);
    end
  endtask

  // Choose a new voltage level for the samples around it; mostly inside the
  // table span, sometimes anywhere, near full scale or near zero.
  task automatic pick_level();
    int unsigned mv_lo, mv_hi;
    case ($urandom_range(0, 9))
      6, 7: level_uv = $urandom_range(0, MaxUv);
      8:    level_uv = $urandom_range(MaxUv - 100000, MaxUv);
      9:    level_uv = $urandom_range(0, 5000);
      default: begin
        mv_lo = (curve_mv[0] > 80) ? curve_mv[0] - 80 : 0;
        mv_hi = curve_mv[TableN-1] + 40;
        if (mv_hi > MaxUv / 1000) mv_hi = MaxUv / 1000;
        level_uv = $urandom_range(mv_hi, mv_lo) * 1000 + $urandom_range(0, 999);
      end
    endcase
    if (level_uv > MaxUv) level_uv = MaxUv;
  endtask

  task automatic run_random(int n);
    int          v;
    int unsigned i, lo, hi;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        case ($urandom_range(0, 9))
          8, 9: begin
            // Out of range index: must be dropped.
            post_entry($urandom_range(TableN, 127), $urandom);
          end
          6, 7: begin
            // Spoil one entry; the table goes non-monotone for a while.
            i = $urandom_range(0, TableN - 1);
            post_entry(i, $urandom);
            dirty_q.push_back(i);
          end
          default: begin
            // Move one entry between its neighbors.
            i  = $urandom_range(0, TableN - 1);
            lo = (i == 0) ? ((curve_mv[0] >= 50) ? curve_mv[0] - 50 : 0) : curve_mv[i-1];
            hi = (i == TableN - 1) ? curve_mv[i] + 50 : curve_mv[i+1];
            if (hi > 65535) hi = 65535;
            curve_mv[i] = MvW'($urandom_range(hi, lo));
            post_entry(i, curve_mv[i]);
          end
        endcase
      end else begin
        if ($urandom_range(0, 7) == 0) pick_level();
        case ($urandom_range(0, 39))
          0:       post_sample(0);
          1:       post_sample(MaxUv);
          default: begin
            v = int'(level_uv) + int'($urandom_range(0, 4000)) - 2000;
            if (v < 0) v = 0;
            if (v > int'(MaxUv)) v = MaxUv;
            post_sample(v);
          end
        endcase
      end
    end
    // Put back spoiled entries before the next phase.
    while (dirty_q.size() != 0) begin
      i = dirty_q.pop_front();
      post_entry(i, curve_mv[i]);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The table has no reset: fill it before any short window can finish.
    load_curve();

    // Directed words with a one-sample short window, so each sample does a
    // lookup, and a two-sample long window.
    set_windows(4'd1, 4'd0);
    post_sample(0);                                  // below entry 0
    post_sample(MaxUv);                              // above the last entry
    post_sample(curve_mv[50] * 1000);                // exact hit mid table
    post_sample(curve_mv[0] * 1000);                 // equal to entry 0
    post_sample(curve_mv[TableN-1] * 1000 + 999);    // equal to the last entry
    post_sample(curve_mv[1] * 1000 + 500);
    post_sample(23'h2AAAAA);
    post_sample(23'h155555);
    post_entry(TableN, 16'hFFFF);                    // dropped index
    post_entry(127, 16'h0000);                       // dropped index
    post_sample(curve_mv[TableN-1] * 1000);
    post_entry(TableN - 1, 16'hFFFF);                // full scale top entry
    post_sample(MaxUv);
    post_entry(TableN - 1, curve_mv[TableN-1]);
    post_entry(0, 16'h0000);                         // zero bottom entry
    post_sample(0);
    post_entry(0, curve_mv[0]);
    post_entry(30, 16'hAAAA);                        // non-monotone table
    post_entry(31, 16'h5555);
    post_sample(curve_mv[40] * 1000);
    post_sample(curve_mv[20] * 1000);
    post_entry(30, curve_mv[30]);
    post_entry(31, curve_mv[31]);

    // Random phases; the long one with out of range shifts runs past one
    // full 256-sample window on both averagers.
    set_windows(4'd0, 4'd0);
    run_random(15);
    set_windows(4'd2, 4'd5);
    run_random(15);
    set_windows(4'd15, 4'd12);
    run_random(300);
    set_windows(4'd8, 4'd3);
    run_random(15);
    set_windows(4'd5, 4'd1);
    run_random(10);

    idle_block();
    if (sb.bad_fields == 0 && sb.due_count() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
